@@ src/fixtv_pkg.sv @@
// Shared widths, byte codes, state encodings and bundle types of the tag=value decoder.
package fixtv_pkg;

    localparam int BYTE_W      = 8;
    localparam int TAG_W       = 16;
    localparam int LEN_W       = 16;
    localparam int FIELD_TAG_W = 16;
    localparam int CFG_W       = 16;
    localparam int ERR_W       = 3;
    localparam int APB_W       = 32;
    localparam int ADDR_W      = 5;

    localparam logic [BYTE_W-1:0] CH_EQ  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
    localparam logic [BYTE_W-1:0] CH_0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9   = 8'h39;

    localparam logic [CFG_W-1:0] RST_CHECKSUM_TAG = 16'd10;
    localparam logic [CFG_W-1:0] RST_DATA_TAG_A   = 16'd89;
    localparam logic [CFG_W-1:0] RST_DATA_TAG_B   = 16'd91;
    localparam logic [CFG_W-1:0] RST_DATA_TAG_C   = 16'd96;
    localparam logic [CFG_W-1:0] RST_DATA_TAG_D   = 16'd213;

    typedef enum logic [2:0] {
        REG_CHECKSUM_TAG = 3'd0,
        REG_DATA_TAG_A   = 3'd1,
        REG_DATA_TAG_B   = 3'd2,
        REG_DATA_TAG_C   = 3'd3,
        REG_DATA_TAG_D   = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_TAG   = 4'b0001,
        PH_VALUE = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_DSEP  = 4'b1000
    } t_phase;

    typedef enum logic [3:0] {
        NS_NONE   = 4'b0001,
        NS_DIGITS = 4'b0010,
        NS_BAD    = 4'b0100,
        NS_DONE   = 4'b1000
    } t_num;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_TAG      = 3'd1,
        ERR_NO_PRIOR = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_SEP      = 3'd4
    } t_err;

    typedef struct packed {
        logic [CFG_W-1:0] checksum_tag;
        logic [CFG_W-1:0] data_tag_a;
        logic [CFG_W-1:0] data_tag_b;
        logic [CFG_W-1:0] data_tag_c;
        logic [CFG_W-1:0] data_tag_d;
    } t_cfg;

    typedef struct packed {
        logic [FIELD_TAG_W-1:0] field_tag;
        logic [BYTE_W-1:0]      value_byte;
        logic                   value_valid;
        logic                   field_end;
        logic                   message_complete;
        logic [BYTE_W-1:0]      checksum_sum;
        t_err                   error_code;
    } t_result;

endpackage

@@ src/fixtv_if.sv @@
// Valid/ready channel interfaces for the input byte word and the result word.
interface fixtv_in_if;
    import fixtv_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface fixtv_out_if;
    import fixtv_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [FIELD_TAG_W-1:0] field_tag;
    logic [BYTE_W-1:0]      value_byte;
    logic                   value_valid;
    logic                   field_end;
    logic                   message_complete;
    logic [BYTE_W-1:0]      checksum_sum;
    logic [ERR_W-1:0]       error_code;

    modport source (output valid, output field_tag, output value_byte, output value_valid,
                    output field_end, output message_complete, output checksum_sum,
                    output error_code, input ready);
    modport sink (input valid, input field_tag, input value_byte, input value_valid,
                  input field_end, input message_complete, input checksum_sum,
                  input error_code, output ready);
endinterface

@@ src/fix_tag_value_decoder.sv @@
// Top level of the tag=value<SOH> message decoder: input register, parser, result register.
// A byte word accepted into the input register moves on into the result register, where the
// sink can take it. Throughput: one byte per cycle while the sink is ready; the parser state
// updates as a word moves from the input register to the result register, and the result
// register frees the input side.
// Reset (i_rst_n low, synchronous): both stages empty, parser at the start of a message,
// registers back to checksum tag 10 and data tags 89, 91, 96, 213.
module fix_tag_value_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fixtv_in_if.sink                      i_in,
    fixtv_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fixtv_pkg::ADDR_W-1:0]  paddr,
    input  logic [fixtv_pkg::APB_W-1:0]   pwdata,
    output logic [fixtv_pkg::APB_W-1:0]   prdata,
    output logic                          pready
);
    import fixtv_pkg::*;

    t_cfg              w_cfg;
    t_result           w_res;
    logic              w_advance;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    fixtv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fixtv_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in_byte),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // advance a word when the result register is empty or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.field_tag        = r_out.field_tag;
    assign o_out.value_byte       = r_out.value_byte;
    assign o_out.value_valid      = r_out.value_valid;
    assign o_out.field_end        = r_out.field_end;
    assign o_out.message_complete = r_out.message_complete;
    assign o_out.checksum_sum     = r_out.checksum_sum;
    assign o_out.error_code       = r_out.error_code;

endmodule

@@ src/fixtv_cfg.sv @@
// APB register file holding the checksum tag and the four data tags.
module fixtv_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fixtv_pkg::ADDR_W-1:0]  paddr,
    input  logic [fixtv_pkg::APB_W-1:0]   pwdata,
    output logic [fixtv_pkg::APB_W-1:0]   prdata,
    output logic                          pready,
    output fixtv_pkg::t_cfg               o_cfg
);
    import fixtv_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.checksum_tag <= RST_CHECKSUM_TAG;
            r_cfg.data_tag_a   <= RST_DATA_TAG_A;
            r_cfg.data_tag_b   <= RST_DATA_TAG_B;
            r_cfg.data_tag_c   <= RST_DATA_TAG_C;
            r_cfg.data_tag_d   <= RST_DATA_TAG_D;
        end else if (w_wr) begin
            case (w_idx)
                REG_CHECKSUM_TAG: r_cfg.checksum_tag <= pwdata[CFG_W-1:0];
                REG_DATA_TAG_A:   r_cfg.data_tag_a   <= pwdata[CFG_W-1:0];
                REG_DATA_TAG_B:   r_cfg.data_tag_b   <= pwdata[CFG_W-1:0];
                REG_DATA_TAG_C:   r_cfg.data_tag_c   <= pwdata[CFG_W-1:0];
                REG_DATA_TAG_D:   r_cfg.data_tag_d   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_CHECKSUM_TAG: prdata = APB_W'(r_cfg.checksum_tag);
            REG_DATA_TAG_A:   prdata = APB_W'(r_cfg.data_tag_a);
            REG_DATA_TAG_B:   prdata = APB_W'(r_cfg.data_tag_b);
            REG_DATA_TAG_C:   prdata = APB_W'(r_cfg.data_tag_c);
            REG_DATA_TAG_D:   prdata = APB_W'(r_cfg.data_tag_d);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ src/fixtv_parse.sv @@
// Field parser state and the per-byte next-state and result logic.
module fixtv_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [fixtv_pkg::BYTE_W-1:0]  i_byte,
    input  fixtv_pkg::t_cfg               i_cfg,
    output fixtv_pkg::t_result            o_res
);
    import fixtv_pkg::*;

    localparam int NUM_W = (TAG_W > LEN_W) ? TAG_W : LEN_W;
    localparam int CMP_W = (TAG_W > CFG_W) ? TAG_W : CFG_W;
    localparam logic [NUM_W+3:0] TAG_LIM = {{(NUM_W+4-TAG_W){1'b0}}, {TAG_W{1'b1}}};
    localparam logic [NUM_W+3:0] LEN_LIM = {{(NUM_W+4-LEN_W){1'b0}}, {LEN_W{1'b1}}};

    typedef struct packed {
        logic [NUM_W-1:0] acc;
        t_num             st;
    } t_scan;

    function automatic t_scan scan_digit(input logic [NUM_W-1:0] acc, input t_num st,
                                         input logic [BYTE_W-1:0] b,
                                         input logic [NUM_W+3:0] limit);
        logic [NUM_W+3:0] v;
        t_scan            r;
        r.acc = acc;
        r.st  = st;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{NUM_W{1'b0}}, b[3:0]};
        if (b inside {[CH_0:CH_9]}) begin
            if (st == NS_NONE || st == NS_DIGITS) begin
                if (v > limit) begin
                    r.st = NS_BAD;
                end else begin
                    r.acc = v[NUM_W-1:0];
                    r.st  = NS_DIGITS;
                end
            end
        end else if (st == NS_NONE) begin
            r.st = NS_BAD;
        end else if (st == NS_DIGITS) begin
            r.st = NS_DONE;
        end
        return r;
    endfunction

    t_phase            r_phase,  n_phase;
    logic [TAG_W-1:0]  r_tag,    n_tag;
    t_num              r_tag_st, n_tag_st;
    logic [BYTE_W-1:0] r_fsum,   n_fsum;
    logic [BYTE_W-1:0] r_msum,   n_msum;
    logic [LEN_W-1:0]  r_cur,    n_cur;
    t_num              r_cur_st, n_cur_st;
    logic [LEN_W-1:0]  r_plen,   n_plen;
    logic              r_plv,    n_plv;
    logic              r_any,    n_any;
    logic [LEN_W-1:0]  r_left,   n_left;

    logic [CMP_W-1:0]  w_tag_ext;
    logic              w_is_data;
    logic              w_is_cks;
    t_scan             w_tag_scan;
    t_scan             w_cur_scan;
    logic              w_cur_ok;
    logic [LEN_W-1:0]  w_left_dec;

    assign w_tag_ext  = CMP_W'(r_tag);
    assign w_is_data  = (w_tag_ext == CMP_W'(i_cfg.data_tag_a))
                     || (w_tag_ext == CMP_W'(i_cfg.data_tag_b))
                     || (w_tag_ext == CMP_W'(i_cfg.data_tag_c))
                     || (w_tag_ext == CMP_W'(i_cfg.data_tag_d));
    assign w_is_cks   = (w_tag_ext == CMP_W'(i_cfg.checksum_tag));
    assign w_tag_scan = scan_digit(NUM_W'(r_tag), r_tag_st, i_byte, TAG_LIM);
    assign w_cur_scan = scan_digit(NUM_W'(r_cur), r_cur_st, i_byte, LEN_LIM);
    assign w_cur_ok   = (r_cur_st == NS_DIGITS) || (r_cur_st == NS_DONE);
    assign w_left_dec = (r_left != '0) ? r_left - 1'b1 : r_left;

    always_comb begin
        logic do_finish;
        logic do_start;
        logic do_restart;
        t_err err;

        n_phase  = r_phase;
        n_tag    = r_tag;
        n_tag_st = r_tag_st;
        n_fsum   = r_fsum;
        n_msum   = r_msum;
        n_cur    = r_cur;
        n_cur_st = r_cur_st;
        n_plen   = r_plen;
        n_plv    = r_plv;
        n_any    = r_any;
        n_left   = r_left;
        o_res    = '0;
        do_finish  = 1'b0;
        do_start   = 1'b0;
        do_restart = 1'b0;
        err        = ERR_NONE;

        case (r_phase)
            PH_TAG: begin
                if (i_byte == CH_EQ) begin
                    if (r_tag_st == NS_NONE || r_tag_st == NS_BAD) begin
                        err = ERR_TAG;
                    end else if (w_is_data) begin
                        if (!r_any) begin
                            err = ERR_NO_PRIOR;
                        end else if (!r_plv) begin
                            err = ERR_LENGTH;
                        end else begin
                            n_left  = r_plen;
                            n_phase = (r_plen == '0) ? PH_DSEP : PH_DATA;
                        end
                    end else begin
                        n_phase = PH_VALUE;
                    end
                    n_cur           = '0;
                    n_cur_st        = NS_NONE;
                    n_fsum          = r_fsum + i_byte;
                    o_res.field_tag = w_tag_ext[FIELD_TAG_W-1:0];
                end else begin
                    n_tag    = w_tag_scan.acc[TAG_W-1:0];
                    n_tag_st = w_tag_scan.st;
                    n_fsum   = r_fsum + i_byte;
                end
            end
            PH_VALUE: begin
                o_res.field_tag = w_tag_ext[FIELD_TAG_W-1:0];
                if (i_byte == CH_SOH) begin
                    do_finish = 1'b1;
                end else begin
                    n_cur             = w_cur_scan.acc[LEN_W-1:0];
                    n_cur_st          = w_cur_scan.st;
                    n_fsum            = r_fsum + i_byte;
                    o_res.value_byte  = i_byte;
                    o_res.value_valid = 1'b1;
                end
            end
            PH_DATA: begin
                o_res.field_tag   = w_tag_ext[FIELD_TAG_W-1:0];
                n_cur             = w_cur_scan.acc[LEN_W-1:0];
                n_cur_st          = w_cur_scan.st;
                n_fsum            = r_fsum + i_byte;
                o_res.value_byte  = i_byte;
                o_res.value_valid = 1'b1;
                n_left            = w_left_dec;
                if (w_left_dec == '0) begin
                    n_phase = PH_DSEP;
                end
            end
            PH_DSEP: begin
                if (i_byte == CH_SOH) begin
                    o_res.field_tag = w_tag_ext[FIELD_TAG_W-1:0];
                    do_finish       = 1'b1;
                end else begin
                    err = ERR_SEP;
                end
            end
            default: begin
                do_restart = 1'b1;
            end
        endcase

        if (do_finish) begin
            o_res.field_end = 1'b1;
            n_any  = 1'b1;
            n_plen = r_cur;
            n_plv  = w_cur_ok;
            if (w_is_cks) begin
                o_res.message_complete = 1'b1;
                o_res.checksum_sum     = r_msum;
                do_restart             = 1'b1;
            end else begin
                n_msum   = r_msum + r_fsum + i_byte;
                do_start = 1'b1;
            end
        end

        // drop the byte and restart the message on any error
        if (err != ERR_NONE) begin
            o_res            = '0;
            o_res.error_code = err;
            do_restart       = 1'b1;
        end

        if (do_start || do_restart) begin
            n_phase  = PH_TAG;
            n_tag    = '0;
            n_tag_st = NS_NONE;
            n_fsum   = '0;
            n_cur    = '0;
            n_cur_st = NS_NONE;
            n_left   = '0;
        end
        if (do_restart) begin
            n_msum = '0;
            n_plen = '0;
            n_plv  = 1'b0;
            n_any  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_tag    <= '0;
            r_tag_st <= NS_NONE;
            r_fsum   <= '0;
            r_msum   <= '0;
            r_cur    <= '0;
            r_cur_st <= NS_NONE;
            r_plen   <= '0;
            r_plv    <= 1'b0;
            r_any    <= 1'b0;
            r_left   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_tag_st <= n_tag_st;
            r_fsum   <= n_fsum;
            r_msum   <= n_msum;
            r_cur    <= n_cur;
            r_cur_st <= n_cur_st;
            r_plen   <= n_plen;
            r_plv    <= n_plv;
            r_any    <= n_any;
            r_left   <= n_left;
        end
    end

endmodule
